// File: hw/rtl/fkc_pkg.sv
// ----------------------------------------------------------------------------
// fkc_pkg
// Shared types and constants for the four-function keypad calculator.
// ----------------------------------------------------------------------------
package fkc_pkg;

	// Arithmetic width of the display and operand registers.
	localparam int DATA_WIDTH = 32;
	// Width of the display value on the result port.
	localparam int OUT_W      = 32;
	// Iteration counter width for the shared multiply/divide unit.
	localparam int CNT_W      = $clog2(DATA_WIDTH);
	// Divisor used by backspace.
	localparam int BACKSPACE_DIV = 10;

	typedef logic [DATA_WIDTH-1:0] data_t;

	// Key kinds as they arrive on req_type.
	typedef enum logic [2:0] {
		KEY_DIGIT = 3'd0,
		KEY_EQUALS = 3'd1,
		KEY_CLEAR = 3'd2,
		KEY_BACK = 3'd3,
		KEY_ADD = 3'd4,
		KEY_SUB = 3'd5,
		KEY_MUL = 3'd6,
		KEY_DIV = 3'd7
	} key_t;

	// Pending operator codes.
	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic mul_step;
		logic div_step;
		logic commit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_mul;
		logic need_div;
		logic last;
	} status_t;

endpackage

// File: hw/rtl/fkc_ctrl.sv
// ----------------------------------------------------------------------------
// fkc_ctrl
// Controller state machine: sequences key load, iteration and commit, and
// owns the request and result handshakes.
// ----------------------------------------------------------------------------
module fkc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	input  fkc_pkg::status_t status,
	output fkc_pkg::cmd_t    cmd
);

	fkc_pkg::state_t state_q;
	fkc_pkg::state_t state_d;
	logic            rsp_valid_q;
	logic            out_free;

	// The result register can take a new value when empty or being drained.
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign req_stall = (state_q != fkc_pkg::ST_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fkc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			fkc_pkg::ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					if (status.need_mul) begin
						state_d = fkc_pkg::ST_MUL;
					end else if (status.need_div) begin
						state_d = fkc_pkg::ST_DIV;
					end else begin
						state_d = fkc_pkg::ST_DONE;
					end
				end
			end
			fkc_pkg::ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (status.last) begin
					state_d = fkc_pkg::ST_DONE;
				end
			end
			fkc_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.last) begin
					state_d = fkc_pkg::ST_DONE;
				end
			end
			fkc_pkg::ST_DONE: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = fkc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fkc_pkg::ST_IDLE;
			end
		endcase
	end

	// Result valid: set on commit, cleared once the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

endmodule

// File: hw/rtl/fkc_dp.sv
// ----------------------------------------------------------------------------
// fkc_dp
// Datapath: calculator state, a shared shift-add multiplier and restoring
// divider (one bit per cycle), and the result register.
// ----------------------------------------------------------------------------
module fkc_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [2:0]                req_type,
	input  logic [3:0]                digit,
	input  fkc_pkg::cmd_t             cmd,
	output fkc_pkg::status_t          status,
	output logic signed [fkc_pkg::OUT_W-1:0] display_value
);

	localparam int DW = fkc_pkg::DATA_WIDTH;

	// Architectural calculator state.
	fkc_pkg::data_t display_q;
	fkc_pkg::data_t operand_q;
	logic [2:0]     op_q;
	logic           fresh_q;

	// Latched key.
	fkc_pkg::key_t  kind_q;
	logic [3:0]     dig_q;

	// Iteration unit.
	fkc_pkg::data_t          work_a_q;
	fkc_pkg::data_t          work_b_q;
	logic [DW:0]             acc_q;
	logic [fkc_pkg::CNT_W-1:0] cnt_q;
	logic                    qneg_q;

	// Result register.
	logic [fkc_pkg::OUT_W-1:0] out_q;

	fkc_pkg::key_t  in_kind;
	fkc_pkg::data_t div_num;
	fkc_pkg::data_t div_den;
	fkc_pkg::data_t num_mag;
	fkc_pkg::data_t den_mag;
	logic           in_is_eq;
	logic [DW:0]    div_shift;
	logic [DW:0]    div_diff;
	fkc_pkg::data_t quot;
	fkc_pkg::data_t new_disp;
	fkc_pkg::data_t new_oper;
	logic [2:0]     new_op;
	logic           new_fresh;

	assign in_kind  = fkc_pkg::key_t'(req_type);
	assign in_is_eq = (in_kind == fkc_pkg::KEY_EQUALS);

	// Decide which keys need the iteration unit.
	assign status.need_mul = in_is_eq && (op_q == fkc_pkg::OP_MUL);
	assign status.need_div = (in_is_eq && (op_q == fkc_pkg::OP_DIV))
		|| (in_kind == fkc_pkg::KEY_BACK);
	assign status.last = (cnt_q == fkc_pkg::CNT_W'(DW - 1));

	// Division operands and their magnitudes.
	assign div_num = in_is_eq ? operand_q : display_q;
	assign div_den = in_is_eq ? display_q : DW'(fkc_pkg::BACKSPACE_DIV);
	assign num_mag = div_num[DW-1] ? (~div_num + 1'b1) : div_num;
	assign den_mag = div_den[DW-1] ? (~div_den + 1'b1) : div_den;

	// One restoring-division step.
	assign div_shift = {acc_q[DW-1:0], work_a_q[DW-1]};
	assign div_diff  = div_shift - {1'b0, work_b_q};

	// Signed quotient, zero on a zero divisor.
	always_comb begin
		if (work_b_q == '0) begin
			quot = '0;
		end else if (qneg_q) begin
			quot = ~work_a_q + 1'b1;
		end else begin
			quot = work_a_q;
		end
	end

	// Key load and iteration unit.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			dig_q  <= digit;
			cnt_q  <= '0;
			acc_q  <= '0;
			if (status.need_mul) begin
				work_a_q <= display_q;
				work_b_q <= operand_q;
				qneg_q   <= 1'b0;
			end else begin
				work_a_q <= num_mag;
				work_b_q <= den_mag;
				qneg_q   <= div_num[DW-1] ^ div_den[DW-1];
			end
		end else if (cmd.mul_step) begin
			cnt_q    <= cnt_q + 1'b1;
			work_a_q <= {1'b0, work_a_q[DW-1:1]};
			work_b_q <= {work_b_q[DW-2:0], 1'b0};
			if (work_a_q[0]) begin
				acc_q <= {1'b0, acc_q[DW-1:0] + work_b_q};
			end
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
			if (!div_diff[DW]) begin
				acc_q    <= div_diff;
				work_a_q <= {work_a_q[DW-2:0], 1'b1};
			end else begin
				acc_q    <= div_shift;
				work_a_q <= {work_a_q[DW-2:0], 1'b0};
			end
		end
	end

	// Next calculator state for the latched key.
	always_comb begin
		new_disp  = display_q;
		new_oper  = operand_q;
		new_op    = op_q;
		new_fresh = fresh_q;
		unique case (kind_q)
			fkc_pkg::KEY_DIGIT: begin
				if (fresh_q) begin
					new_disp = DW'(dig_q);
				end else begin
					new_disp = (display_q << 3) + (display_q << 1) + DW'(dig_q);
				end
				new_fresh = 1'b0;
			end
			fkc_pkg::KEY_EQUALS: begin
				unique case (op_q)
					fkc_pkg::OP_ADD: new_disp = operand_q + display_q;
					fkc_pkg::OP_SUB: new_disp = operand_q - display_q;
					fkc_pkg::OP_MUL: new_disp = acc_q[DW-1:0];
					fkc_pkg::OP_DIV: new_disp = quot;
					default:         new_disp = display_q;
				endcase
				new_op    = fkc_pkg::OP_NONE;
				new_fresh = 1'b1;
			end
			fkc_pkg::KEY_CLEAR: begin
				new_disp  = '0;
				new_oper  = '0;
				new_op    = fkc_pkg::OP_NONE;
				new_fresh = 1'b0;
			end
			fkc_pkg::KEY_BACK: begin
				new_disp = quot;
			end
			fkc_pkg::KEY_ADD: begin
				new_oper  = display_q;
				new_op    = fkc_pkg::OP_ADD;
				new_fresh = 1'b1;
			end
			fkc_pkg::KEY_SUB: begin
				new_oper  = display_q;
				new_op    = fkc_pkg::OP_SUB;
				new_fresh = 1'b1;
			end
			fkc_pkg::KEY_MUL: begin
				new_oper  = display_q;
				new_op    = fkc_pkg::OP_MUL;
				new_fresh = 1'b1;
			end
			fkc_pkg::KEY_DIV: begin
				new_oper  = display_q;
				new_op    = fkc_pkg::OP_DIV;
				new_fresh = 1'b1;
			end
			default: begin
				new_disp = display_q;
			end
		endcase
	end

	// Calculator state, updated when the key is committed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_q <= '0;
			operand_q <= '0;
			op_q      <= fkc_pkg::OP_NONE;
			fresh_q   <= 1'b0;
		end else if (cmd.commit) begin
			display_q <= new_disp;
			operand_q <= new_oper;
			op_q      <= new_op;
			fresh_q   <= new_fresh;
		end
	end

	// Result register, loaded on commit and held while stalled.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= fkc_pkg::OUT_W'(new_disp);
		end
	end

	assign display_value = out_q;

endmodule

// File: hw/rtl/four_function_keypad_calculator_unit.sv
// ----------------------------------------------------------------------------
// four_function_keypad_calculator_unit
// Keypad calculator: one key press in, the display contents after it out.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   request   req_valid/req_stall   req_type[2:0], digit[3:0]
//   result    rsp_valid/rsp_stall   display_value[31:0] (signed)
//
// Digit, clear and operator keys, and equals with add, subtract or no
// operator pending, are loaded and then committed; equals with multiply,
// equals with divide and backspace first run 32 bit steps of the shared
// shift-add/restoring-divide unit. A new key is accepted only in the idle
// state, while the previous result may still wait in the output register.
// Reset clears the controller and calculator state, not the result
// register. A stalled result holds and delays the next commit.
//
module four_function_keypad_calculator_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic [2:0]                req_type,
	input  logic [3:0]                digit,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic signed [fkc_pkg::OUT_W-1:0] display_value
);

	fkc_pkg::cmd_t    cmd;
	fkc_pkg::status_t status;

	// Sequencing and handshakes.
	fkc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// State and arithmetic.
	fkc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_type      (req_type),
		.digit         (digit),
		.cmd           (cmd),
		.status        (status),
		.display_value (display_value)
	);

endmodule
